FILE: sv/dpsc_pkg.sv
// ============================================================================
// dpsc_pkg: shared constants for the dual-axis PID step controller
// Register indexes, command and limit codes, field widths and defaults.
// ============================================================================
package dpsc_pkg;

  // Default fixed-point and deadband settings
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int DEADBAND_DEF        = 1311;

  // Field widths
  localparam int ANG_W      = 32;   // signed angle
  localparam int GAIN_W     = 32;   // unsigned Q8.24 gain
  localparam int GAIN_FRAC  = 24;
  localparam int MAXA_W     = 31;   // unsigned saturation angle
  localparam int INT_W      = 48;   // integral store
  localparam int ACC_W      = 60;   // sum of three gain products
  localparam int STEP_W     = 8;
  localparam int LIM_W      = 2;
  localparam int DIV_W      = MAXA_W + GAIN_FRAC;  // clamp dividend width
  localparam int RATE_DIV   = 7;                    // slew limit is max/7

  // max/7 as a reciprocal multiply: ceil(2^34/7), exact for 31-bit angles
  localparam logic [31:0] RATE_RECIP = 32'h9249_2493;
  localparam int          RATE_SH    = 34;

  // Stream widths
  localparam int IN_TDATA_W  = 4 * ANG_W;
  localparam int OUT_TDATA_W = 24;  // 18 bits of fields, padded to bytes
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AZ_KP          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AZ_KI_DT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AZ_KD_OVER_DT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_KP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_KI_DT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_KD_OVER_DT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_DEG  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE      = 3'd7;

  // Command codes carried in tuser
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Limit state codes
  localparam logic [LIM_W-1:0] LIM_WITHIN = 2'd0;
  localparam logic [LIM_W-1:0] LIM_HIGH   = 2'd1;
  localparam logic [LIM_W-1:0] LIM_LOW    = 2'd2;
  localparam logic [LIM_W-1:0] LIM_NONE   = 2'd3;  // never produced

endpackage

FILE: sv/dual_axis_pid_step_controller.sv
// ============================================================================
// dual_axis_pid_step_controller: two-axis PID update with anti-windup,
// slew limit, saturation and conversion to motor steps
// ============================================================================
//
// Channel     Dir  Handshake                  Payload
// ---------   ---  -------------------------  --------------------------------
// s_axis      in   s_axis_tvalid/tready       tdata: az_pos, alt_pos, az_tgt,
//                                             alt_tgt; tuser: cmd
// m_axis      out  m_axis_tvalid/tready       tdata: az_steps, alt_steps,
//                                             az_limit_state
// cfg         in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// An update beat holds the sequencer from the accepting idle cycle through
// 20 steps per axis on one shared 32x32 multiplier to the output state,
// which loads the result into the output register once it is free.
// A clear beat leaves the sequencer idle and gives no result.
// After a run of configuration writes, recompute the two anti-windup clamps on
// a bit-serial divider and the slew step on the multiplier, with s_axis_tready
// low throughout. s_axis_tready also stays low while cfg_valid is high.
// A finished result waits in the output register; a new beat is taken
// meanwhile, and the sequencer holds at its end until the register drains.
// After reset no recompute is needed: config and derived registers read zero.
// ============================================================================
module dual_axis_pid_step_controller
  import dpsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int DEADBAND        = DEADBAND_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input beats
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [31:0] az_position, [63:32] alt_position, [95:64] az_target,
  // [127:96] alt_target
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] cmd
  input  logic [0:0]             s_axis_tuser_i,
  // result beats
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] az_step_count, [15:8] alt_step_count, [17:16] az_limit_state,
  // [23:18] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [GAIN_W-1:0]      cfg_data_i
);

  // Step rounding: steps = round(|out| * spd / 2^(16+F))
  localparam int          STEP_SH   = 16 + ANGLE_FRAC_BITS;
  localparam logic [63:0] STEP_HALF = 64'd1 << (STEP_SH - 1);
  localparam logic [63:0] GAIN_HALF = 64'd1 << (GAIN_FRAC - 1);
  localparam logic signed [ANG_W-1:0] DB_S = ANG_W'(DEADBAND);
  localparam logic [DIV_W-1:0] I48_MAX = DIV_W'({1'b0, {(INT_W-1){1'b1}}});

  // Sequencer codes
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DLOAD  = 5'd1;
  localparam logic [4:0] ST_DSTEP  = 5'd2;
  localparam logic [4:0] ST_DSTORE = 5'd3;
  localparam logic [4:0] ST_ERR    = 5'd4;
  localparam logic [4:0] ST_SUM    = 5'd5;
  localparam logic [4:0] ST_TLOAD  = 5'd6;
  localparam logic [4:0] ST_TMLO   = 5'd7;
  localparam logic [4:0] ST_TMHI   = 5'd8;
  localparam logic [4:0] ST_TACC   = 5'd9;
  localparam logic [4:0] ST_LIMA   = 5'd10;
  localparam logic [4:0] ST_LIMB   = 5'd11;
  localparam logic [4:0] ST_SATC   = 5'd12;
  localparam logic [4:0] ST_STEPA  = 5'd13;
  localparam logic [4:0] ST_STEPM  = 5'd14;
  localparam logic [4:0] ST_STEPR  = 5'd15;
  localparam logic [4:0] ST_OUT    = 5'd16;
  localparam logic [4:0] ST_RATE   = 5'd17;

  // Gain term codes
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // Divider job codes
  localparam logic [1:0] DJ_AZ_CLAMP  = 2'd0;
  localparam logic [1:0] DJ_ALT_CLAMP = 2'd1;

  logic [4:0] state_q, state_d;

  // Configuration registers
  logic [GAIN_W-1:0] az_kp_q, az_ki_q, az_kd_q;
  logic [GAIN_W-1:0] alt_kp_q, alt_ki_q, alt_kd_q;
  logic [GAIN_W-1:0] spd_q;
  logic [MAXA_W-1:0] max_angle_q;

  // Values derived from configuration
  logic              stale_q;
  logic [MAXA_W-1:0] rate_q;
  logic [INT_W-1:0]  clamp_q [2];

  // Per-axis controller state
  logic signed [INT_W-1:0] integ_q [2];
  logic signed [ANG_W-1:0] perr_q  [2];
  logic signed [ANG_W-1:0] pout_q  [2];

  // Captured beat
  logic signed [ANG_W-1:0] pos_q [2];
  logic signed [ANG_W-1:0] tgt_q [2];

  // Working registers
  logic                    ax_q;
  logic [1:0]              tm_q;
  logic signed [ANG_W-1:0] e_q;
  logic signed [INT_W-1:0] sum_q;
  logic signed [ANG_W:0]   d_q;
  logic                    neg_q;
  logic [INT_W-1:0]        mag_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [63:0]             prod_q;
  logic [32:0]             lor_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [33:0]      hi_q, lo_q, u_q;
  logic signed [ANG_W-1:0] out_q;
  logic [ANG_W-1:0]        smag_q;
  logic [STEP_W-1:0]       step_q [2];
  logic [LIM_W-1:0]        lim_q;

  // Divider
  logic [1:0]        dj_q;
  logic [5:0]        cnt_q;
  logic [31:0]       rem_q;
  logic [DIV_W-1:0]  quot_q;
  logic [31:0]       dsor_q;

  // Output register
  logic              m_valid_q;
  logic [STEP_W-1:0] m_az_q, m_alt_q;
  logic [LIM_W-1:0]  m_lim_q;

  logic s_acc, cfg_acc, out_load;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);

  // A pending write wins over an input beat in the same idle cycle
  assign s_axis_tready_o = (state_q == ST_IDLE) && !stale_q && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'd0, m_lim_q, m_alt_q, m_az_q};

  // --------------------------------------------------------------------------
  // Shared multiplier and its operand selection
  // --------------------------------------------------------------------------
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (state_q)
      ST_TMLO: begin
        mul_a = {8'd0, mag_q[23:0]};
        mul_b = gain_q;
      end
      ST_TMHI: begin
        mul_a = {8'd0, mag_q[47:24]};
        mul_b = gain_q;
      end
      ST_STEPM: begin
        mul_a = smag_q;
        mul_b = spd_q;
      end
      ST_RATE: begin
        mul_a = {1'b0, max_angle_q};
        mul_b = RATE_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Gain for the current axis and term
  logic [GAIN_W-1:0] gain_sel, ki_cur;

  assign ki_cur = ax_q ? alt_ki_q : az_ki_q;

  always_comb begin
    case (tm_q)
      TERM_P:  gain_sel = ax_q ? alt_kp_q : az_kp_q;
      TERM_I:  gain_sel = ki_cur;
      TERM_D:  gain_sel = ax_q ? alt_kd_q : az_kd_q;
      default: gain_sel = '0;
    endcase
  end

  // Term operand, sign-extended to 49 bits
  logic signed [INT_W:0] opnd;

  always_comb begin
    case (tm_q)
      TERM_P:  opnd = {{(INT_W-ANG_W+1){e_q[ANG_W-1]}}, e_q};
      TERM_I:  opnd = {sum_q[INT_W-1], sum_q};
      TERM_D:  opnd = {{(INT_W-ANG_W){d_q[ANG_W]}}, d_q};
      default: opnd = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic signed [ANG_W:0]   diff;
  logic signed [INT_W:0]   sum_ext;
  logic signed [INT_W:0]   opnd_neg;
  logic [63:0]             lo_rnd;
  logic [57:0]             term_r;
  logic signed [ACC_W-1:0] term_ext;
  logic signed [ACC_W-1:0] hi_ext, lo_ext;
  logic signed [33:0]      maxa_s;
  logic signed [INT_W-1:0] clamp_s;
  logic [63:0]             step_rnd, step_r;
  logic [STEP_W-1:0]       steps;
  logic [32:0]             dsh;
  logic [33:0]             dtrial;
  logic                    dbit;
  logic [DIV_W-1:0]        dividend;

  assign diff     = {tgt_q[ax_q][ANG_W-1], tgt_q[ax_q]}
                  - {pos_q[ax_q][ANG_W-1], pos_q[ax_q]};
  assign sum_ext  = {integ_q[ax_q][INT_W-1], integ_q[ax_q]}
                  + {{(INT_W-ANG_W+1){e_q[ANG_W-1]}}, e_q};
  assign opnd_neg = -opnd;
  assign lo_rnd   = prod_q + GAIN_HALF;
  assign term_r   = prod_q[57:0] + {25'd0, lor_q};
  assign term_ext = $signed({2'b00, term_r});
  assign hi_ext   = {{(ACC_W-34){hi_q[33]}}, hi_q};
  assign lo_ext   = {{(ACC_W-34){lo_q[33]}}, lo_q};
  assign maxa_s   = $signed({3'b000, max_angle_q});
  assign clamp_s  = $signed(clamp_q[ax_q]);
  assign step_rnd = prod_q + STEP_HALF;
  assign step_r   = step_rnd >> STEP_SH;

  always_comb begin
    if (out_q[ANG_W-1]) begin
      steps = (step_r > 64'd128) ? 8'h80 : (~step_r[7:0] + 8'd1);
    end else begin
      steps = (step_r > 64'd127) ? 8'h7f : step_r[7:0];
    end
  end

  // Restoring divider step
  assign dsh    = {rem_q, quot_q[DIV_W-1]};
  assign dtrial = {1'b0, dsh} - {2'b00, dsor_q};
  assign dbit   = !dtrial[33];

  // Both clamp jobs divide max_angle * 2^24 by the axis integral gain
  assign dividend = {max_angle_q, {GAIN_FRAC{1'b0}}};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          state_d = ST_IDLE;
        end else if (stale_q) begin
          state_d = ST_DLOAD;
        end else if (s_acc && s_axis_tuser_i[0] == CMD_UPDATE) begin
          state_d = ST_ERR;
        end
      end
      ST_DLOAD:  state_d = ST_DSTEP;
      ST_DSTEP:  state_d = (cnt_q == 6'(DIV_W - 1)) ? ST_DSTORE : ST_DSTEP;
      ST_DSTORE: state_d = (dj_q == DJ_ALT_CLAMP) ? ST_RATE : ST_DLOAD;
      ST_RATE:   state_d = ST_IDLE;
      ST_ERR:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_TLOAD;
      ST_TLOAD:  state_d = ST_TMLO;
      ST_TMLO:   state_d = ST_TMHI;
      ST_TMHI:   state_d = ST_TACC;
      ST_TACC:   state_d = (tm_q == TERM_D) ? ST_LIMA : ST_TLOAD;
      ST_LIMA:   state_d = ST_LIMB;
      ST_LIMB:   state_d = ST_SATC;
      ST_SATC:   state_d = ST_STEPA;
      ST_STEPA:  state_d = ST_STEPM;
      ST_STEPM:  state_d = ST_STEPR;
      ST_STEPR:  state_d = ax_q ? ST_OUT : ST_ERR;
      ST_OUT:    state_d = out_load ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control, configuration and controller state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_q     <= 1'b0;
      az_kp_q     <= '0;
      az_ki_q     <= '0;
      az_kd_q     <= '0;
      alt_kp_q    <= '0;
      alt_ki_q    <= '0;
      alt_kd_q    <= '0;
      spd_q       <= '0;
      max_angle_q <= '0;
      rate_q      <= '0;
      clamp_q[0]  <= '0;
      clamp_q[1]  <= '0;
      integ_q[0]  <= '0;
      integ_q[1]  <= '0;
      perr_q[0]   <= '0;
      perr_q[1]   <= '0;
      pout_q[0]   <= '0;
      pout_q[1]   <= '0;
      ax_q        <= 1'b0;
      tm_q        <= TERM_P;
      dj_q        <= DJ_AZ_CLAMP;
      cnt_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      // Any write invalidates the derived clamps and slew step
      if (cfg_acc) begin
        stale_q <= 1'b1;
        case (cfg_index_i)
          REG_AZ_KP:          az_kp_q     <= cfg_data_i;
          REG_AZ_KI_DT:       az_ki_q     <= cfg_data_i;
          REG_AZ_KD_OVER_DT:  az_kd_q     <= cfg_data_i;
          REG_ALT_KP:         alt_kp_q    <= cfg_data_i;
          REG_ALT_KI_DT:      alt_ki_q    <= cfg_data_i;
          REG_ALT_KD_OVER_DT: alt_kd_q    <= cfg_data_i;
          REG_STEPS_PER_DEG:  spd_q       <= cfg_data_i;
          REG_MAX_ANGLE:      max_angle_q <= cfg_data_i[MAXA_W-1:0];
          default:            ;
        endcase
      end else if (state_q == ST_IDLE && stale_q) begin
        stale_q <= 1'b0;
        dj_q    <= DJ_AZ_CLAMP;
      end

      // Clear command: drop integrals and previous errors, keep outputs
      if (s_acc && s_axis_tuser_i[0] == CMD_CLEAR) begin
        integ_q[0] <= '0;
        integ_q[1] <= '0;
        perr_q[0]  <= '0;
        perr_q[1]  <= '0;
      end

      if (s_acc && s_axis_tuser_i[0] == CMD_UPDATE) begin
        ax_q <= 1'b0;
      end

      case (state_q)
        ST_DLOAD: cnt_q <= '0;
        ST_DSTEP: cnt_q <= cnt_q + 6'd1;
        ST_DSTORE: begin
          case (dj_q)
            DJ_AZ_CLAMP: clamp_q[0] <= (quot_q > I48_MAX) ? I48_MAX[INT_W-1:0]
                                                          : quot_q[INT_W-1:0];
            default:     clamp_q[1] <= (quot_q > I48_MAX) ? I48_MAX[INT_W-1:0]
                                                          : quot_q[INT_W-1:0];
          endcase
          dj_q <= dj_q + 2'd1;
        end
        // Slew step = floor(max/7) by reciprocal multiply
        ST_RATE: rate_q  <= MAXA_W'(mul_p >> RATE_SH);
        ST_SUM:  tm_q <= TERM_P;
        ST_TACC: tm_q <= tm_q + 2'd1;
        ST_STEPA: begin
          // Commit the axis state; the previous output is still needed above
          integ_q[ax_q] <= sum_q;
          perr_q[ax_q]  <= e_q;
          pout_q[ax_q]  <= (e_q < DB_S && e_q > -DB_S) ? '0 : out_q;
        end
        ST_STEPR: ax_q <= 1'b1;
        default: ;
      endcase

      // Output register: load at the end of an update, drop once taken
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload and working registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pos_q[0] <= s_axis_tdata_i[31:0];
      pos_q[1] <= s_axis_tdata_i[63:32];
      tgt_q[0] <= s_axis_tdata_i[95:64];
      tgt_q[1] <= s_axis_tdata_i[127:96];
    end

    case (state_q)
      ST_DLOAD: begin
        rem_q  <= '0;
        quot_q <= dividend;
        case (dj_q)
          DJ_AZ_CLAMP: dsor_q <= az_ki_q;
          default:     dsor_q <= alt_ki_q;
        endcase
      end
      ST_DSTEP: begin
        rem_q  <= dbit ? dtrial[31:0] : dsh[31:0];
        quot_q <= {quot_q[DIV_W-2:0], dbit};
      end
      ST_ERR: begin
        // Saturate the error to 32 bits
        if (diff[ANG_W] != diff[ANG_W-1]) begin
          e_q <= diff[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
        end else begin
          e_q <= diff[ANG_W-1:0];
        end
      end
      ST_SUM: begin
        if (sum_ext[INT_W] != sum_ext[INT_W-1]) begin
          sum_q <= sum_ext[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
          sum_q <= sum_ext[INT_W-1:0];
        end
        d_q   <= {e_q[ANG_W-1], e_q} - {perr_q[ax_q][ANG_W-1], perr_q[ax_q]};
        acc_q <= '0;
      end
      ST_TLOAD: begin
        neg_q  <= opnd[INT_W];
        mag_q  <= opnd[INT_W] ? opnd_neg[INT_W-1:0] : opnd[INT_W-1:0];
        gain_q <= gain_sel;
      end
      ST_TMLO: prod_q <= mul_p;
      ST_TMHI: begin
        lor_q  <= lo_rnd[56:24];
        prod_q <= mul_p;
      end
      ST_TACC: acc_q <= neg_q ? acc_q - term_ext : acc_q + term_ext;
      ST_LIMA: begin
        hi_q <= {{2{pout_q[ax_q][ANG_W-1]}}, pout_q[ax_q]} + $signed({3'b000, rate_q});
        lo_q <= {{2{pout_q[ax_q][ANG_W-1]}}, pout_q[ax_q]} - $signed({3'b000, rate_q});
        // Anti-windup clamp of the stored sum
        if (ki_cur != '0) begin
          if (sum_q > clamp_s) begin
            sum_q <= clamp_s;
          end else if (sum_q < -clamp_s) begin
            sum_q <= -clamp_s;
          end
        end
      end
      ST_LIMB: begin
        if (acc_q > hi_ext) begin
          u_q <= hi_q;
        end else if (acc_q < lo_ext) begin
          u_q <= lo_q;
        end else begin
          u_q <= acc_q[33:0];
        end
      end
      ST_SATC: begin
        if (u_q > maxa_s) begin
          out_q <= maxa_s[ANG_W-1:0];
          if (!ax_q) lim_q <= LIM_HIGH;
        end else if (u_q < -maxa_s) begin
          out_q <= -maxa_s[ANG_W-1:0];
          if (!ax_q) lim_q <= LIM_LOW;
        end else begin
          out_q <= u_q[ANG_W-1:0];
          if (!ax_q) lim_q <= LIM_WITHIN;
        end
      end
      ST_STEPA: smag_q <= out_q[ANG_W-1] ? (~out_q + 32'd1) : out_q;
      ST_STEPM: prod_q <= mul_p;
      ST_STEPR: step_q[ax_q] <= steps;
      default: ;
    endcase

    if (out_load) begin
      m_az_q  <= step_q[0];
      m_alt_q <= step_q[1];
      m_lim_q <= lim_q;
    end
  end

endmodule

FILE: sv/dpsc_checker.sv
// ============================================================================
// dpsc_checker: port-level checks for the dual-axis PID step controller
// Watches handshakes and result beats over time; attached by bind.
// ============================================================================
module dpsc_checker
  import dpsc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [0:0]             s_axis_tuser_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o
);

  // A configuration write always triggers a recompute before the next beat
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready_o)
    else $error("input ready right after a configuration write");

  // An update beat keeps the sequencer busy
  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0] == CMD_UPDATE
    |=> !s_axis_tready_o)
    else $error("input ready right after an update beat");

  // A clear beat gives no result
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0] == CMD_CLEAR
    |=> !$rose(m_axis_tvalid_o))
    else $error("result raised by a clear beat");

  // Result padding is zero and the limit code is a real one
  a_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[23:18] == 6'd0
                        && m_axis_tdata_o[17:16] != LIM_NONE)
    else $error("malformed result beat");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

endmodule

bind dual_axis_pid_step_controller dpsc_checker u_dpsc_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the dual-axis PID step controller
// Feeds control ticks and clear commands, predicts each result beat (step
// counts and azimuth limit state) from its own fixed-point PID and compares
// every beat with the oldest prediction. Gain sets change between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpsc_pkg::*;

  // Wait after the last result before a register write or the end, long
  // enough to cover any tick still in flight.
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_PRINTS    = 100;

  localparam longint ERR_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam int     STEP_SHIFT = 16 + ANGLE_FRAC_BITS_DEF;

  // One control tick as sent on the input stream
  typedef struct packed {
    logic            cmd;
    logic [ANG_W-1:0] az_pos;
    logic [ANG_W-1:0] alt_pos;
    logic [ANG_W-1:0] az_tgt;
    logic [ANG_W-1:0] alt_tgt;
  } tick_t;

  // One result beat
  typedef struct packed {
    logic [LIM_W-1:0]  az_lim;
    logic [STEP_W-1:0] alt_steps;
    logic [STEP_W-1:0] az_steps;
  } steps_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = CMD_UPDATE;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_AZ_KP;
  logic [GAIN_W-1:0]      cfg_data = '0;

  // Ticks waiting to be sent, predicted results waiting to arrive
  tick_t  tick_backlog[$];
  steps_t expected_steps[$];
  tick_t  cur_tick;
  int     ticks_queued = 0;
  int     ticks_taken  = 0;
  int     mismatches   = 0;
  int     gap_pct      = 8;   // chance per cycle that the sender idles
  int     stall_pct    = 8;   // chance per cycle that the receiver stalls

  // Shadow of the configuration registers
  logic [GAIN_W-1:0] az_kp_q, az_ki_q, az_kd_q;
  logic [GAIN_W-1:0] alt_kp_q, alt_ki_q, alt_kd_q;
  logic [GAIN_W-1:0] steps_per_deg_q;
  logic [MAXA_W-1:0] max_angle_q;

  // Shadow of the per-axis state (index 0 azimuth, 1 altitude)
  longint err_sum[2];
  longint last_err[2];
  longint last_out[2];

  dual_axis_pid_step_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point PID prediction
  // --------------------------------------------------------------------------

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // a * g / 2^24, rounded half away from zero; split to stay inside 64 bits
  function automatic longint scale_q24(longint a, logic [GAIN_W-1:0] g);
    logic        neg;
    logic [63:0] mag, hi, lo, r;
    neg = (a < 0);
    mag = neg ? -a : a;
    hi  = mag >> GAIN_FRAC;
    lo  = mag & 64'h00FF_FFFF;
    r   = hi * {32'd0, g} + ((lo * {32'd0, g} + 64'h0080_0000) >> GAIN_FRAC);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Angle to motor steps, rounded half away from zero, held to 8 bits
  function automatic logic [STEP_W-1:0] to_motor_steps(longint ang);
    logic        neg;
    logic [63:0] mag, r;
    neg = (ang < 0);
    mag = neg ? -ang : ang;
    r   = (mag * {32'd0, steps_per_deg_q} + (64'd1 << (STEP_SHIFT - 1))) >> STEP_SHIFT;
    if (neg) return (r > 128) ? 8'h80 : 8'(-r);
    return (r > 127) ? 8'h7F : 8'(r);
  endfunction

  task automatic axis_update(input int ax, input logic [ANG_W-1:0] pos, tgt,
                             input logic [GAIN_W-1:0] kp, ki, kd,
                             output logic [STEP_W-1:0] steps,
                             output logic [LIM_W-1:0] lim);
    longint      maxa, rate, e, sum, u, prev, c;
    logic [63:0] q;
    maxa = longint'({33'd0, max_angle_q});
    rate = maxa / RATE_DIV;
    e    = clip(longint'($signed(tgt)) - longint'($signed(pos)), ERR_MAX);
    sum  = clip(err_sum[ax] + e, SUM_MAX);
    u    = scale_q24(e, kp) + scale_q24(sum, ki) + scale_q24(e - last_err[ax], kd);
    prev = last_out[ax];
    // Anti-windup acts on the stored sum only, after the output is formed
    if (ki != '0) begin
      q = ({33'd0, max_angle_q} << GAIN_FRAC) / {32'd0, ki};
      c = (q > SUM_MAX) ? SUM_MAX : longint'(q);
      if (sum > c) sum = c;
      else if (sum < -c) sum = -c;
    end
    // Slew limit against the previous output, then saturate
    if (u - prev > rate) u = prev + rate;
    else if (prev - u > rate) u = prev - rate;
    lim = LIM_WITHIN;
    if (u > maxa) begin
      u   = maxa;
      lim = LIM_HIGH;
    end else if (u < -maxa) begin
      u   = -maxa;
      lim = LIM_LOW;
    end
    steps        = to_motor_steps(u);
    err_sum[ax]  = sum;
    last_err[ax] = e;
    // Inside the deadband the next slew starts from zero
    last_out[ax] = (e < DEADBAND_DEF && e > -DEADBAND_DEF) ? 0 : u;
  endtask

  // Advance the shadow state by one accepted tick, queue its result if any
  task automatic predict_steps(input tick_t t);
    steps_t           r;
    logic [LIM_W-1:0] alt_lim;
    if (t.cmd == CMD_CLEAR) begin
      // Clear keeps the previous outputs and gives no result
      err_sum  = '{0, 0};
      last_err = '{0, 0};
      return;
    end
    axis_update(0, t.az_pos, t.az_tgt, az_kp_q, az_ki_q, az_kd_q,
                r.az_steps, r.az_lim);
    axis_update(1, t.alt_pos, t.alt_tgt, alt_kp_q, alt_ki_q, alt_kd_q,
                r.alt_steps, alt_lim);
    expected_steps.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns: %s: expected 'h%0h, got 'h%0h", $time, what, want, got);
  endtask

  task automatic check_beat(input logic [OUT_TDATA_W-1:0] beat);
    steps_t want;
    if (expected_steps.size() == 0) begin
      flag_mismatch("result beat with nothing outstanding", '0, beat);
      return;
    end
    want = expected_steps.pop_front();
    if (beat[7:0] !== want.az_steps)
      flag_mismatch("az_step_count", want.az_steps, beat[7:0]);
    if (beat[15:8] !== want.alt_steps)
      flag_mismatch("alt_step_count", want.alt_steps, beat[15:8]);
    if (beat[17:16] !== want.az_lim)
      flag_mismatch("az_limit_state", want.az_lim, beat[17:16]);
    if (beat[OUT_TDATA_W-1:18] !== '0)
      flag_mismatch("tdata padding", '0, beat[OUT_TDATA_W-1:18]);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the backlog one beat at a time, idle at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Predict on the edge that takes the beat, while the config is stable
      if (s_axis_tvalid && s_axis_tready_o) begin
        predict_steps(cur_tick);
        ticks_taken = ticks_taken + 1;
      end
      // Hold a beat until it is taken; only then pick the next one
      if (!s_axis_tvalid || s_axis_tready_o) begin
        if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          cur_tick = tick_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_tick.alt_tgt, cur_tick.az_tgt,
                            cur_tick.alt_pos, cur_tick.az_pos};
          s_axis_tuser  <= cur_tick.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result beat, stall at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready) check_beat(m_axis_tdata_o);
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_tick(input logic cmd, input logic [ANG_W-1:0] az_pos, alt_pos,
                           input logic [ANG_W-1:0] az_tgt, alt_tgt);
    tick_backlog.push_back('{cmd, az_pos, alt_pos, az_tgt, alt_tgt});
    ticks_queued++;
  endtask

  // Target a short way off the position, at one of a few scales
  function automatic logic [ANG_W-1:0] near_angle(logic [ANG_W-1:0] base);
    int span;
    case ($urandom_range(0, 3))
      0:       span = 1400;       // straddles the deadband
      1:       span = 1 << 18;
      2:       span = 1 << 23;
      default: span = 1 << 29;
    endcase
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [ANG_W-1:0] extreme_angle();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h8000_0000 + $urandom_range(0, 255);
    endcase
  endfunction

  // Mostly tracking ticks with small errors, some noise, a few clears
  task automatic push_random_ticks(input int n);
    int               roll;
    logic [ANG_W-1:0] azp, altp;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      azp  = $urandom();
      altp = $urandom();
      if (roll < 5)
        push_tick(CMD_CLEAR, azp, altp, $urandom(), $urandom());
      else if (roll < 75)
        push_tick(CMD_UPDATE, azp, altp, near_angle(azp), near_angle(altp));
      else if (roll < 92)
        push_tick(CMD_UPDATE, azp, altp, $urandom(), $urandom());
      else
        push_tick(CMD_UPDATE, extreme_angle(), extreme_angle(),
                  extreme_angle(), extreme_angle());
    end
  endtask

  // Write one register; leave valid high so a following write runs on
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_AZ_KP:          az_kp_q = val;
      REG_AZ_KI_DT:       az_ki_q = val;
      REG_AZ_KD_OVER_DT:  az_kd_q = val;
      REG_ALT_KP:         alt_kp_q = val;
      REG_ALT_KI_DT:      alt_ki_q = val;
      REG_ALT_KD_OVER_DT: alt_kd_q = val;
      REG_STEPS_PER_DEG:  steps_per_deg_q = val;
      REG_MAX_ANGLE:      max_angle_q = val[MAXA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [GAIN_W-1:0] azp, azi, azd, altp, alti, altd,
                           input logic [GAIN_W-1:0] spd, maxa);
    @(posedge clk_i);
    cfg_write(REG_AZ_KP, azp);
    cfg_write(REG_AZ_KI_DT, azi);
    cfg_write(REG_AZ_KD_OVER_DT, azd);
    cfg_write(REG_ALT_KP, altp);
    cfg_write(REG_ALT_KI_DT, alti);
    cfg_write(REG_ALT_KD_OVER_DT, altd);
    cfg_write(REG_STEPS_PER_DEG, spd);
    cfg_write(REG_MAX_ANGLE, maxa);
    cfg_valid <= 1'b0;
  endtask

  // Stop feeding until every tick is taken and every result is in, then
  // let a trailing clear or late beat settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (ticks_taken != ticks_queued || expected_steps.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    az_kp_q = '0;  az_ki_q = '0;  az_kd_q = '0;
    alt_kp_q = '0; alt_ki_q = '0; alt_kd_q = '0;
    steps_per_deg_q = '0;
    max_angle_q     = '0;
    err_sum  = '{0, 0};
    last_err = '{0, 0};
    last_out = '{0, 0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers at reset: every output reads zero steps
    push_tick(CMD_UPDATE, 32'h0, 32'h0, 32'h0, 32'h0);
    push_tick(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_tick(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Nominal tracking gains: 10 steps/deg, 3.5 deg range (35 steps)
    load_regs(32'h0100_0000, 32'h0002_8F5C, 32'h0019_999A,
              32'h0200_0000, 32'h0005_1EB8, 32'h000C_CCCD,
              32'h000A_0000, 32'h0003_8000);
    push_tick(CMD_UPDATE, 32'h0, 32'h0, 32'h0, 32'h0);
    // just inside and just outside the deadband
    push_tick(CMD_UPDATE, 32'h0, 32'h0, 32'd1310, -32'sd1310);
    push_tick(CMD_UPDATE, 32'h0, 32'h0, 32'd1311, -32'sd1311);
    // saturated errors: slew up a max/7 per tick until the high clip
    for (int i = 0; i < 8; i++)
      push_tick(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_tick(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
    // a deadband tick drops the stored output, then slew down to the low clip
    push_tick(CMD_UPDATE, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 8; i++)
      push_tick(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_tick(CMD_CLEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_random_ticks(300);
    wait_drained();

    // Every register at its top value; max angle write drops its top bit
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_random_ticks(150);
    wait_drained();

    // Strong integral on azimuth with a small range: anti-windup clamps hard
    load_regs(32'h0100_0000, 32'hFFFF_FFFF, 32'h0,
              $urandom(), 32'h0000_0001, $urandom_range(0, 32'h0100_0000),
              32'h0014_0000, 32'h0002_0000);
    push_random_ticks(150);
    wait_drained();

    // Random registers, and a long stretch with no idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    load_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom());
    push_random_ticks(200);
    wait_drained();
    gap_pct   = 8;
    stall_pct = 8;

    // Pure derivative, no integral clamp, small step scale
    load_regs(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, $urandom(),
              $urandom_range(0, 1 << 20), $urandom_range(1, 1 << 22));
    push_random_ticks(200);
    wait_drained();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: dual_axis_pid_step_controller.f
sv/dpsc_pkg.sv
sv/dual_axis_pid_step_controller.sv
sv/dpsc_checker.sv
tb/tb_top.sv
